@@ hw/rtl/fqr_pkg.sv @@
// shared types for the fifo queue with remove by id
// request codes, result status codes and the per-cell control struct
// no dependencies
package fqr_pkg;

    typedef enum logic [2:0] {
        FUNC_ENQ    = 3'd0,
        FUNC_DEQ    = 3'd1,
        FUNC_PEEK   = 3'd2,
        FUNC_REMOVE = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // one operation broadcast to every cell, already gated by accept
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
        logic clr;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/fqr_cell.sv @@
// one storage cell of the queue: occupied flag, identifier and payload
// shifts toward the head, loads on enqueue, compares for remove
// depends on fqr_pkg
module fqr_cell import fqr_pkg::*; #(
    parameter int ID_BITS      = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cell_ctrl_t              ctrl,
    input  logic [ID_BITS-1:0]      key_id,
    input  logic [PAYLOAD_BITS-1:0] key_payload,
    input  logic                    prev_occ,
    input  logic                    next_occ,
    input  logic [ID_BITS-1:0]      next_id,
    input  logic [PAYLOAD_BITS-1:0] next_payload,
    input  logic                    hit_in,
    output logic                    hit_out,
    output logic                    occ,
    output logic [ID_BITS-1:0]      id,
    output logic [PAYLOAD_BITS-1:0] payload
);

    logic                    occ_reg, occ_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                    shift;
    logic                    load;

    // hit_out is high from the first matching cell to the tail
    assign hit_out = hit_in | (occ_reg && (id_reg == key_id));
    assign shift   = ctrl.deq | (ctrl.rem & hit_out);
    // the first free cell takes the new item
    assign load    = ctrl.enq & ~occ_reg & prev_occ;

    always_comb begin
        priority if (ctrl.clr) begin
            occ_next     = 1'b0;
            id_next      = id_reg;
            payload_next = payload_reg;
        end else if (shift) begin
            occ_next     = next_occ;
            id_next      = next_id;
            payload_next = next_payload;
        end else if (load) begin
            occ_next     = 1'b1;
            id_next      = key_id;
            payload_next = key_payload;
        end else begin
            occ_next     = occ_reg;
            id_next      = id_reg;
            payload_next = payload_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg      <= id_next;
        payload_reg <= payload_next;
    end

    assign occ     = occ_reg;
    assign id      = id_reg;
    assign payload = payload_reg;

endmodule

@@ hw/rtl/fifo_queue_remove_by_id.sv @@
// fifo queue with remove by id, built as a row of cells, head at cell 0
// result: registered when the item is accepted, valid in the following cycle
// throughput: one item per cycle while m_ready takes each result; removal is a single
//   pass of the per-cell compare and a ripple of the first-match flag along the row
// reset: synchronous active-low aresetn empties the queue and drops any pending result
module fifo_queue_remove_by_id import fqr_pkg::*; #(
    parameter int DEPTH        = 16,
    parameter int ID_BITS      = 16,
    parameter int PAYLOAD_BITS = 32,
    localparam int CNT_BITS    = $clog2(DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_func,
    input  logic [ID_BITS-1:0]      s_entry_id,
    input  logic [PAYLOAD_BITS-1:0] s_entry_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [ID_BITS-1:0]      m_out_id,
    output logic [PAYLOAD_BITS-1:0] m_out_payload,
    output logic [CNT_BITS-1:0]     m_count
);

    logic                    occ_w [DEPTH];
    logic [ID_BITS-1:0]      id_w [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_w [DEPTH];
    logic                    hit_w [DEPTH+1];

    cell_ctrl_t              ctrl;
    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    found;

    logic                    m_valid_reg, m_valid_next;
    status_t                 status_reg, status_next;
    logic [ID_BITS-1:0]      out_id_reg, out_id_next;
    logic [PAYLOAD_BITS-1:0] out_payload_reg, out_payload_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign full    = occ_w[DEPTH-1];
    assign empty   = ~occ_w[0];
    assign found   = hit_w[DEPTH];
    assign hit_w[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                    prev_occ;
        logic                    next_occ;
        logic [ID_BITS-1:0]      next_id;
        logic [PAYLOAD_BITS-1:0] next_payload;

        if (i == 0) begin : g_head
            assign prev_occ = 1'b1;
        end else begin : g_mid
            assign prev_occ = occ_w[i-1];
        end

        // the tail cell shifts in an empty slot
        if (i == DEPTH - 1) begin : g_tail
            assign next_occ     = 1'b0;
            assign next_id      = id_w[i];
            assign next_payload = pay_w[i];
        end else begin : g_body
            assign next_occ     = occ_w[i+1];
            assign next_id      = id_w[i+1];
            assign next_payload = pay_w[i+1];
        end

        fqr_cell #(
            .ID_BITS      (ID_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .key_id       (s_entry_id),
            .key_payload  (s_entry_payload),
            .prev_occ     (prev_occ),
            .next_occ     (next_occ),
            .next_id      (next_id),
            .next_payload (next_payload),
            .hit_in       (hit_w[i]),
            .hit_out      (hit_w[i+1]),
            .occ          (occ_w[i]),
            .id           (id_w[i]),
            .payload      (pay_w[i])
        );
    end

    always_comb begin
        ctrl             = '0;
        status_next      = ST_DONE;
        out_id_next      = '0;
        out_payload_next = '0;
        count_next       = count_reg;
        unique case (s_func)
            FUNC_ENQ: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.enq   = accept;
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            FUNC_DEQ, FUNC_PEEK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    out_id_next      = id_w[0];
                    out_payload_next = pay_w[0];
                    if (s_func == FUNC_DEQ) begin
                        ctrl.deq   = accept;
                        count_next = count_reg - CNT_BITS'(1);
                    end
                end
            end
            FUNC_REMOVE: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!found) begin
                    status_next = ST_NOTFOUND;
                end else begin
                    ctrl.rem   = accept;
                    count_next = count_reg - CNT_BITS'(1);
                end
            end
            FUNC_CLEAR: begin
                ctrl.clr   = accept;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg      <= status_next;
            out_id_reg      <= out_id_next;
            out_payload_reg <= out_payload_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_out_id      = out_id_reg;
    assign m_out_payload = out_payload_reg;
    assign m_count       = count_reg;

endmodule

@@ hw/rtl/fqr_checker.sv @@
// port-level checks for the fifo queue with remove by id, bound to the top level
// depends on fqr_pkg and fifo_queue_remove_by_id
module fqr_props import fqr_pkg::*; #(
    parameter int DEPTH        = 16,
    parameter int ID_BITS      = 16,
    parameter int PAYLOAD_BITS = 32,
    localparam int CNT_BITS    = $clog2(DEPTH + 1)
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [2:0]              s_func,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [1:0]              m_status,
    input logic [ID_BITS-1:0]      m_out_id,
    input logic [PAYLOAD_BITS-1:0] m_out_payload,
    input logic [CNT_BITS-1:0]     m_count
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_id)
            && $stable(m_out_payload) && $stable(m_count))
        else $error("result changed while stalled");

    // clear always empties the queue
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_CLEAR |=>
            m_valid && m_count == '0 && m_status == ST_DONE)
        else $error("clear did not empty the queue");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_count == '0)
        else $error("empty status with entries held");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_count == CNT_BITS'(DEPTH))
        else $error("full status below depth");

    // a returned entry only comes with a done status
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_id != '0 || m_out_payload != '0) |-> m_status == ST_DONE)
        else $error("entry returned on a failed request");

endmodule

bind fifo_queue_remove_by_id fqr_props #(
    .DEPTH        (DEPTH),
    .ID_BITS      (ID_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_fqr_props (.*);

@@ dv/fqr_checker.sv @@
`timescale 1ns / 100ps
// checker for fifo_queue_remove_by_id: watches both handshakes, keeps its own copy of the queue
// and compares every result with the predicted one; depends on fqr_pkg
module fqr_checker import fqr_pkg::*; #(
    parameter int DEPTH        = 16,
    parameter int ID_BITS      = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int CNT_BITS     = $clog2(DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [2:0]              s_func,
    input  logic [ID_BITS-1:0]      s_entry_id,
    input  logic [PAYLOAD_BITS-1:0] s_entry_payload,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [1:0]              m_status,
    input  logic [ID_BITS-1:0]      m_out_id,
    input  logic [PAYLOAD_BITS-1:0] m_out_payload,
    input  logic [CNT_BITS-1:0]     m_count,
    output int                      fail_count,
    output int                      outstanding,
    output int                      results_checked
);

    typedef struct packed {
        status_t                 status;
        logic [ID_BITS-1:0]      id;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [CNT_BITS-1:0]     count;
    } queue_result_t;

    // shadow copy of the queue, head at index 0
    logic [ID_BITS-1:0]      shadow_id [DEPTH];
    logic [PAYLOAD_BITS-1:0] shadow_payload [DEPTH];
    int                      shadow_count;

    queue_result_t           awaited_results[$];

    // close the gap left at position pos
    task automatic close_gap(input int pos);
        for (int i = pos + 1; i < shadow_count; i++) begin
            shadow_id[i-1]      = shadow_id[i];
            shadow_payload[i-1] = shadow_payload[i];
        end
        shadow_count--;
    endtask

    task automatic apply_request(
        input  logic [2:0]              func,
        input  logic [ID_BITS-1:0]      id,
        input  logic [PAYLOAD_BITS-1:0] payload,
        output queue_result_t           res
    );
        int hit;
        res        = '0;
        res.status = ST_DONE;
        case (func)
            FUNC_ENQ: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_id[shadow_count]      = id;
                    shadow_payload[shadow_count] = payload;
                    shadow_count++;
                end
            end
            FUNC_DEQ, FUNC_PEEK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.id      = shadow_id[0];
                    res.payload = shadow_payload[0];
                    if (func == FUNC_DEQ) begin
                        close_gap(0);
                    end
                end
            end
            FUNC_REMOVE: begin
                hit = -1;
                for (int i = 0; i < shadow_count; i++) begin
                    if (hit < 0 && shadow_id[i] == id) begin
                        hit = i;
                    end
                end
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (hit < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    close_gap(hit);
                end
            end
            FUNC_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
                // unused codes leave the queue alone
            end
        endcase
        res.count = CNT_BITS'(shadow_count);
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        queue_result_t res;
        if (!aresetn) begin
            awaited_results.delete();
            shadow_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_func, s_entry_id, s_entry_payload, res);
                awaited_results.push_back(res);
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result st %0h id %0h pay %0h cnt %0d",
                             $time, m_status, m_out_id, m_out_payload, m_count);
                    fail_count++;
                end else begin
                    res = awaited_results.pop_front();
                    compare_field("status", 64'(res.status), 64'(m_status));
                    compare_field("out_id", 64'(res.id), 64'(m_out_id));
                    compare_field("out_payload", 64'(res.payload), 64'(m_out_payload));
                    compare_field("count", 64'(res.count), 64'(m_count));
                    results_checked++;
                end
            end
        end
        outstanding <= awaited_results.size();
    end

endmodule

@@ dv/tb_fifo_queue_remove_by_id.sv @@
`timescale 1ns / 100ps
// testbench top for fifo_queue_remove_by_id: clock, reset, directed and random requests,
// random stalls on both channels and the verdict; depends on fqr_pkg and fqr_checker
module tb_fifo_queue_remove_by_id import fqr_pkg::*;;

    localparam int DEPTH        = 16;
    localparam int ID_BITS      = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int PHASE_ITEMS  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // codes the block has to ignore
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [2:0]              s_func          = '0;
    logic [ID_BITS-1:0]      s_entry_id      = '0;
    logic [PAYLOAD_BITS-1:0] s_entry_payload = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [1:0]              m_status;
    logic [ID_BITS-1:0]      m_out_id;
    logic [PAYLOAD_BITS-1:0] m_out_payload;
    logic [CNT_BITS-1:0]     m_count;

    int fail_count;
    int outstanding;
    int results_checked;
    int sender_idle_pct   = 22;
    int receiver_idle_pct = 66;
    int items_sent        = 0;
    int stall_cycles      = 0;

    fifo_queue_remove_by_id #(
        .DEPTH        (DEPTH),
        .ID_BITS      (ID_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_entry_id      (s_entry_id),
        .s_entry_payload (s_entry_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_id        (m_out_id),
        .m_out_payload   (m_out_payload),
        .m_count         (m_count)
    );

    fqr_checker #(
        .DEPTH        (DEPTH),
        .ID_BITS      (ID_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_entry_id      (s_entry_id),
        .s_entry_payload (s_entry_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_id        (m_out_id),
        .m_out_payload   (m_out_payload),
        .m_count         (m_count),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // ends the run when neither channel moves an item for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles, %0d results still due",
                     $time, STALL_LIMIT, outstanding);
            $display("tb_fifo_queue_remove_by_id: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // valid is only dropped when a gap follows, never between back-to-back items
    task automatic send_item(input logic [2:0] func, input logic [ID_BITS-1:0] id,
                             input logic [PAYLOAD_BITS-1:0] payload);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= func;
        s_entry_id      <= id;
        s_entry_payload <= payload;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    // bursts alternate between filling and draining so the queue swings between empty and full
    task automatic send_random_items(input int n);
        int         done_items;
        int         pick;
        int         enq_pct;
        logic [2:0] func;
        logic [ID_BITS-1:0] id;
        done_items = 0;
        while (done_items < n) begin
            enq_pct = ((done_items / 32) % 2 == 0) ? 60 : 20;
            pick    = $urandom_range(99);
            if (pick < 3) begin
                func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
            end else if (pick < 5) begin
                func = FUNC_CLEAR;
            end else if (pick < 5 + enq_pct) begin
                func = FUNC_ENQ;
            end else begin
                pick = $urandom_range(9);
                func = (pick < 4) ? FUNC_DEQ : (pick < 6) ? FUNC_PEEK : FUNC_REMOVE;
            end
            // small id pool so removes hit and duplicates are common
            id = ($urandom_range(99) < 85) ? ID_BITS'($urandom_range(7)) : ID_BITS'($urandom);
            send_item(func, id, $urandom);
            if (func <= FUNC_CLEAR) begin
                done_items++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue, then fill to the brim with repeated ids
        send_item(FUNC_DEQ, '0, '0);
        send_item(FUNC_PEEK, '1, '1);
        send_item(FUNC_REMOVE, '0, '0);
        send_item(FUNC_ENQ, '0, '0);
        send_item(FUNC_ENQ, '1, '1);
        for (int i = 2; i < DEPTH; i++) begin
            send_item(FUNC_ENQ, ID_BITS'(i % 5), $urandom);
        end
        send_item(FUNC_ENQ, 16'h1234, 32'h5555_aaaa);
        send_item(FUNC_PEEK, '0, '0);
        send_item(FUNC_REMOVE, 16'h4321, '0);
        // id 3 sits in three cells, only the one nearest the head goes
        send_item(FUNC_REMOVE, 16'd3, '1);
        send_item(FUNC_DEQ, '1, '1);
        send_item(FUNC_SPARE_LO, '1, '1);
        send_item(FUNC_SPARE_HI, '0, '1);
        send_item(FUNC_CLEAR, '1, '0);

        send_random_items(PHASE_ITEMS);
        sender_idle_pct   = 66;
        receiver_idle_pct <= 22;
        send_random_items(PHASE_ITEMS);
        sender_idle_pct   = 0;
        receiver_idle_pct <= 0;
        send_random_items(PHASE_ITEMS);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d requests: directed empty/full/duplicate-id cases, then fill and drain",
                 items_sent);
        $display("bursts under three stall mixes, %0d results checked", results_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_fifo_queue_remove_by_id: PASS");
        end else begin
            $display("tb_fifo_queue_remove_by_id: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/fqr_pkg.sv
hw/rtl/fqr_cell.sv
hw/rtl/fifo_queue_remove_by_id.sv
hw/rtl/fqr_checker.sv
dv/fqr_checker.sv
dv/tb_fifo_queue_remove_by_id.sv
